// ===== sv/pwli_pkg.sv =====
package pwli_pkg;

    localparam int DATA_W    = 16;
    localparam int CNT_W     = 5;
    localparam int IDX_W     = 4;
    localparam int DIV_STEPS = 16;

    // command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    // how the result is formed: a stored point as is, or a segment interpolation
    typedef enum logic {
        SEL_POINT,
        SEL_SEGMENT
    } sel_t;

    // control that rides along with a convert word
    typedef struct packed {
        logic                     too_short;
        sel_t                     sel;
        logic                     neg;
        logic signed [DATA_W-1:0] y0;
    } res_ctl_t;

    // one divider stage: high half is the partial remainder, low half
    // shifts out dividend bits and shifts in quotient bits
    typedef struct packed {
        res_ctl_t              ctl;
        logic [DATA_W-1:0]     dx;
        logic [2*DATA_W-1:0]   work;
    } div_stage_t;

endpackage

// ===== sv/pwli_ram.sv =====
module pwli_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== sv/piecewise_linear_interpolator.sv =====
// Channel   Direction  Handshake           Word
// in        input      in_valid/in_ready   command, entry_index, entry_raw, entry_value, sample
// out       output     out_valid/out_ready value, table_too_short
// cfg       input      cfg_we              cfg_wdata (point count)
//
// One word enters per cycle while in_ready is high; a convert raises out_valid after passing
// through 22 register stages (compare, table read, differences, multiply, magnitude,
// 16 divider stages, output register).
// The divider is a restoring one, one quotient bit per stage.
// Loads give no result and leave the pipeline after the table write.
// rst_n clears the valid bits and the point count; the table is not cleared.
// Each stage holds its word under stall, and bubbles are squeezed out.
module piecewise_linear_interpolator
    import pwli_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CNT_W-1:0]         cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     command,
    input  logic [IDX_W-1:0]         entry_index,
    input  logic [DATA_W-1:0]        entry_raw,
    input  logic signed [DATA_W-1:0] entry_value,
    input  logic [DATA_W-1:0]        sample,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] value,
    output logic                     table_too_short
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // ------------------------------------------------------------------
    // point count register; the effective count is saturated to the table depth
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] point_count_reg;
    logic [CW-1:0]    n_eff;
    logic             too_short;
    logic [AW-1:0]    last_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            point_count_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (int'(point_count_reg) > TABLE_DEPTH)
        begin
            n_eff = CW'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = CW'(point_count_reg);
        end
    end

    assign too_short = (n_eff < CW'(2));
    assign last_idx  = AW'(n_eff - CW'(1));

    // ------------------------------------------------------------------
    // stall chain: a stage loads when it is empty or its word moves on
    // ------------------------------------------------------------------
    logic             s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, out_v_reg;
    logic             dv_reg [DIV_STEPS];
    logic             ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_o;
    logic             ld_d [DIV_STEPS];

    always_comb
    begin
        ld_o = !out_v_reg || out_ready;
        ld_d[DIV_STEPS-1] = !dv_reg[DIV_STEPS-1] || ld_o;
        for (int k = DIV_STEPS - 2; k >= 0; k--)
        begin
            ld_d[k] = !dv_reg[k] || ld_d[k+1];
        end
        ld_s5 = !s5_v_reg || ld_d[0];
        ld_s4 = !s4_v_reg || ld_s5;
        ld_s3 = !s3_v_reg || ld_s4;
        ld_s2 = !s2_v_reg || ld_s3;
        ld_s1 = !s1_v_reg || ld_s2;
    end

    assign in_ready = ld_s1;

    logic in_fire;
    logic load_ok;
    assign in_fire = in_valid && in_ready;
    assign load_ok = (int'(entry_index) < TABLE_DEPTH);

    // ------------------------------------------------------------------
    // comparator copy of the breakpoint inputs, written on load accept
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] raw_reg [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (in_fire && command == CMD_LOAD && load_ok)
        begin
            raw_reg[AW'(entry_index)] <= entry_raw;
        end
    end

    logic [TABLE_DEPTH-1:0] gt, lt, hit;
    logic                   found;
    logic [AW-1:0]          seg_idx;
    logic [AW-1:0]          sel_addr;
    sel_t                   sel_kind;

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            gt[i]  = raw_reg[i] > sample;
            lt[i]  = raw_reg[i] < sample;
            hit[i] = gt[i] && (i >= 1) && (i < int'(n_eff));
        end
    end

    // first breakpoint above the sample closes the segment
    always_comb
    begin
        found   = 1'b0;
        seg_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 1; i--)
        begin
            if (hit[i])
            begin
                found   = 1'b1;
                seg_idx = AW'(i - 1);
            end
        end
    end

    always_comb
    begin
        if (gt[0])
        begin
            sel_kind = SEL_POINT;        // below the curve
            sel_addr = '0;
        end
        else if (lt[last_idx])
        begin
            sel_kind = SEL_POINT;        // above the curve
            sel_addr = last_idx;
        end
        else if (found)
        begin
            sel_kind = SEL_SEGMENT;
            sel_addr = seg_idx;
        end
        else
        begin
            sel_kind = SEL_POINT;        // sample on the last breakpoint
            sel_addr = last_idx;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: registered select, or a pending load for the RAMs
    // ------------------------------------------------------------------
    logic                     s1_cmd_reg;
    res_ctl_t                 s1_ctl_reg;
    logic [AW-1:0]            s1_addr_reg;
    logic [DATA_W-1:0]        s1_sample_reg;
    logic                     s1_wen_reg;
    logic [AW-1:0]            s1_waddr_reg;
    logic [DATA_W-1:0]        s1_wraw_reg;
    logic signed [DATA_W-1:0] s1_wval_reg;

    always_ff @(posedge clk)
    begin
        if (ld_s1)
        begin
            s1_cmd_reg           <= command;
            s1_ctl_reg.too_short <= too_short;
            s1_ctl_reg.sel       <= sel_kind;
            s1_ctl_reg.neg       <= 1'b0;
            s1_ctl_reg.y0        <= '0;
            s1_addr_reg          <= sel_addr;
            s1_sample_reg        <= sample;
            s1_wen_reg           <= load_ok;
            s1_waddr_reg         <= AW'(entry_index);
            s1_wraw_reg          <= entry_raw;
            s1_wval_reg          <= entry_value;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: table read of both segment ends
    // ------------------------------------------------------------------
    logic                     ram_we;
    logic [DATA_W-1:0]        x0_rd, x1_rd;
    logic [DATA_W-1:0]        y0_rd, y1_rd;
    logic [AW-1:0]            addr_b;

    assign ram_we = s1_v_reg && ld_s2 && s1_cmd_reg == CMD_LOAD && s1_wen_reg;
    assign addr_b = s1_addr_reg + AW'(1);

    pwli_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_raw_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (s1_waddr_reg),
        .wdata   (s1_wraw_reg),
        .re      (ld_s2),
        .raddr_a (s1_addr_reg),
        .raddr_b (addr_b),
        .rdata_a (x0_rd),
        .rdata_b (x1_rd)
    );

    pwli_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_val_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (s1_waddr_reg),
        .wdata   (s1_wval_reg),
        .re      (ld_s2),
        .raddr_a (s1_addr_reg),
        .raddr_b (addr_b),
        .rdata_a (y0_rd),
        .rdata_b (y1_rd)
    );

    res_ctl_t          s2_ctl_reg;
    logic [DATA_W-1:0] s2_sample_reg;

    always_ff @(posedge clk)
    begin
        if (ld_s2)
        begin
            s2_ctl_reg    <= s1_ctl_reg;
            s2_sample_reg <= s1_sample_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: offsets into the segment
    // ------------------------------------------------------------------
    res_ctl_t                 s3_ctl_reg;
    logic [DATA_W:0]          s3_d_reg;
    logic signed [DATA_W:0]   s3_dy_reg;
    logic [DATA_W-1:0]        s3_dx_reg;

    always_ff @(posedge clk)
    begin
        if (ld_s3)
        begin
            s3_ctl_reg.too_short <= s2_ctl_reg.too_short;
            s3_ctl_reg.sel       <= s2_ctl_reg.sel;
            s3_ctl_reg.neg       <= s2_ctl_reg.neg;
            s3_ctl_reg.y0        <= $signed(y0_rd);
            s3_d_reg      <= {1'b0, s2_sample_reg} - {1'b0, x0_rd};
            s3_dy_reg     <= $signed({y1_rd[DATA_W-1], y1_rd})
                           - $signed({y0_rd[DATA_W-1], y0_rd});
            s3_dx_reg     <= x1_rd - x0_rd;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: product, stage 5: sign and magnitude
    // ------------------------------------------------------------------
    res_ctl_t                  s4_ctl_reg;
    logic signed [2*DATA_W+2:0] s4_prod_reg;
    logic signed [2*DATA_W+2:0] prod_next;
    logic [DATA_W-1:0]         s4_dx_reg;

    assign prod_next = $signed({1'b0, s3_d_reg}) * s3_dy_reg;

    always_ff @(posedge clk)
    begin
        if (ld_s4)
        begin
            s4_ctl_reg  <= s3_ctl_reg;
            s4_prod_reg <= prod_next;
            s4_dx_reg   <= s3_dx_reg;
        end
    end

    div_stage_t                 s5_reg;
    logic signed [2*DATA_W+2:0] prod_abs;

    assign prod_abs = s4_prod_reg[2*DATA_W+2] ? -s4_prod_reg : s4_prod_reg;

    always_ff @(posedge clk)
    begin
        if (ld_s5)
        begin
            s5_reg.ctl.too_short <= s4_ctl_reg.too_short;
            s5_reg.ctl.sel       <= s4_ctl_reg.sel;
            s5_reg.ctl.neg       <= s4_prod_reg[2*DATA_W+2];
            s5_reg.ctl.y0        <= s4_ctl_reg.y0;
            s5_reg.dx      <= s4_dx_reg;
            s5_reg.work    <= prod_abs[2*DATA_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // divider: one restoring step per stage, quotient fits 16 bits
    // since the offset is below the segment width
    // ------------------------------------------------------------------
    div_stage_t d_reg  [DIV_STEPS];
    div_stage_t d_next [DIV_STEPS];

    always_comb
    begin
        div_stage_t    src;
        logic [DATA_W:0] trial;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            src   = (k == 0) ? s5_reg : d_reg[(k == 0) ? 0 : k - 1];
            trial = src.work[2*DATA_W-1:DATA_W-1];
            d_next[k].ctl = src.ctl;
            d_next[k].dx  = src.dx;
            if (trial >= {1'b0, src.dx})
            begin
                d_next[k].work = {DATA_W'(trial - {1'b0, src.dx}),
                                  src.work[DATA_W-2:0], 1'b1};
            end
            else
            begin
                d_next[k].work = {trial[DATA_W-1:0], src.work[DATA_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if (ld_d[k])
            begin
                d_reg[k] <= d_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // output register: sign back, offset from y0
    // ------------------------------------------------------------------
    div_stage_t               dl;
    logic signed [DATA_W:0]   quot_s;
    logic signed [DATA_W:0]   sum_s;
    logic signed [DATA_W-1:0] value_next;
    logic signed [DATA_W-1:0] value_reg;
    logic                     short_reg;

    assign dl     = d_reg[DIV_STEPS-1];
    assign quot_s = dl.ctl.neg ? -$signed({1'b0, dl.work[DATA_W-1:0]})
                               : $signed({1'b0, dl.work[DATA_W-1:0]});
    assign sum_s  = $signed({dl.ctl.y0[DATA_W-1], dl.ctl.y0}) + quot_s;

    always_comb
    begin
        if (dl.ctl.too_short)
        begin
            value_next = '0;
        end
        else if (dl.ctl.sel == SEL_POINT)
        begin
            value_next = dl.ctl.y0;
        end
        else
        begin
            value_next = sum_s[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_o)
        begin
            value_reg <= value_next;
            short_reg <= dl.ctl.too_short;
        end
    end

    assign out_valid       = out_v_reg;
    assign value           = value_reg;
    assign table_too_short = short_reg;

    // ------------------------------------------------------------------
    // valid bits; loads drop out after the table write
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (ld_s1) s1_v_reg <= in_valid;
            if (ld_s2) s2_v_reg <= s1_v_reg && s1_cmd_reg == CMD_CONVERT;
            if (ld_s3) s3_v_reg <= s2_v_reg;
            if (ld_s4) s4_v_reg <= s3_v_reg;
            if (ld_s5) s5_v_reg <= s4_v_reg;
            if (ld_d[0]) dv_reg[0] <= s5_v_reg;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                if (ld_d[k]) dv_reg[k] <= dv_reg[k-1];
            end
            if (ld_o) out_v_reg <= dv_reg[DIV_STEPS-1];
        end
    end

endmodule

// ===== sv/pwli_checker.sv =====
module pwli_checker
    import pwli_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [DATA_W-1:0] value,
    input logic                     table_too_short
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(table_too_short))
        else $error("result changed while stalled");

    // a short table always gives zero
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_too_short |-> value == '0)
        else $error("short table with nonzero value");

    // empty output register means the whole pipe can move
    a_ready_free: assert property (@(posedge clk)
        !out_valid |-> in_ready)
        else $error("input stalled with output register empty");

    // reset empties the output
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result shown during reset");

endmodule

bind piecewise_linear_interpolator pwli_checker u_pwli_checker (.*);

// ===== sim/piecewise_linear_interpolator_tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the breakpoint interpolator.
// A queue of pending words feeds a falling-edge driver; a rising-edge monitor
// pops the oldest expected result and compares it field by field.
module piecewise_linear_interpolator_tb;
    import pwli_pkg::*;

    localparam int DEPTH       = 16;
    localparam int DRAIN       = 40;       // settle margin for trailing loads to clear the pipe
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic                     cmd;
        logic [IDX_W-1:0]         idx;
        logic [DATA_W-1:0]        raw;
        logic signed [DATA_W-1:0] val;
        logic [DATA_W-1:0]        smp;
    } word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     too_short;
    } conv_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic command = 1'b0;
    logic [IDX_W-1:0] entry_index = '0;
    logic [DATA_W-1:0] entry_raw = '0;
    logic signed [DATA_W-1:0] entry_value = '0;
    logic [DATA_W-1:0] sample = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [DATA_W-1:0] value;
    logic table_too_short;

    piecewise_linear_interpolator #(.TABLE_DEPTH(DEPTH)) uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .entry_index(entry_index), .entry_raw(entry_raw),
        .entry_value(entry_value), .sample(sample),
        .out_valid(out_valid), .out_ready(out_ready),
        .value(value), .table_too_short(table_too_short)
    );

    always #5 clk = ~clk;

    // predictor state: its own copy of the curve and the count
    logic [DATA_W-1:0]        curve_raw [DEPTH];
    logic signed [DATA_W-1:0] curve_val [DEPTH];
    int                       points_used;

    word_t pending_words[$];
    conv_t expected_conv[$];
    int    errors = 0;
    int    cycles = 0;
    bit    gaps_on = 1'b1;      // random idling on both sides
    bit    hold_sink = 1'b0;    // long receiver hold-off request
    bit    hold_done = 1'b0;
    int    hold_cnt = 0;
    bit    in_taken = 1'b0;     // input accepted at the last rising edge

    // curve lookup, exact product, quotient truncated toward zero
    function automatic conv_t lookup_curve(logic [DATA_W-1:0] x);
        conv_t r;
        longint x0, x1, y0, y1, q;
        int n, seg;
        n = (points_used > DEPTH) ? DEPTH : points_used;
        r.too_short = 1'b0;
        if (n < 2) begin
            r.value = '0;
            r.too_short = 1'b1;
            return r;
        end
        if (x < curve_raw[0]) begin
            r.value = curve_val[0];
            return r;
        end
        if (x > curve_raw[n-1]) begin
            r.value = curve_val[n-1];
            return r;
        end
        seg = n;
        for (int i = 0; i + 1 < n; i++)
            if (curve_raw[i+1] > x) begin
                seg = i;
                break;
            end
        if (seg >= n) begin
            r.value = curve_val[n-1];
            return r;
        end
        x0 = curve_raw[seg];
        x1 = curve_raw[seg+1];
        y0 = curve_val[seg];
        y1 = curve_val[seg+1];
        if (x1 - x0 <= 0) q = 0;
        else q = ((longint'(x) - x0) * (y1 - y0)) / (x1 - x0);
        r.value = DATA_W'(y0 + q);
        return r;
    endfunction

    // applied at acceptance so expectations follow the order words entered
    function automatic void absorb_word(word_t w);
        if (w.cmd == CMD_LOAD) begin
            curve_raw[w.idx] = w.raw;
            curve_val[w.idx] = w.val;
        end else begin
            expected_conv.push_back(lookup_curve(w.smp));
        end
    endfunction

    always @(posedge clk) in_taken <= rst_n && in_valid && in_ready;

    // ---------------------------------------------------------------- driver
    int src_gap = 0;
    always @(negedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
        if (in_taken) begin
            // accepted at the rising edge just past
            absorb_word(pending_words.pop_front());
        end
        if (rst_n && (!in_valid || in_taken)) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                if (gaps_on && $urandom_range(0, 15) == 0) begin
                    src_gap <= $urandom_range(1, 19);
                    in_valid <= 1'b0;
                end else begin
                    in_valid    <= 1'b1;
                    command     <= pending_words[0].cmd;
                    entry_index <= pending_words[0].idx;
                    entry_raw   <= pending_words[0].raw;
                    entry_value <= pending_words[0].val;
                    sample      <= pending_words[0].smp;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ----------------------------------------------------------- sink stalls
    int sink_gap = 0;
    always @(negedge clk) begin
        if (!rst_n) out_ready <= 1'b0;
        else if (hold_sink && !hold_done) begin
            out_ready <= 1'b0;
            if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            out_ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 15) == 0) begin
            sink_gap <= $urandom_range(1, 19);
            out_ready <= 1'b0;
        end else out_ready <= 1'b1;
    end

    // --------------------------------------------------------------- monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_conv.size() == 0) begin
                errors <= errors + 1;
                if (errors < 10)
                    $display("unexpected result: value=%0d short=%0b",
                             value, table_too_short);
            end else begin
                conv_t e;
                e = expected_conv.pop_front();
                if (e.value !== value || e.too_short !== table_too_short) begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("mismatch: exp value=%0d short=%0b, got value=%0d short=%0b",
                                 e.value, e.too_short, value, table_too_short);
                end
            end
        end
    end

    // ------------------------------------------------------------- stimulus
    function automatic word_t load_word(int idx, logic [DATA_W-1:0] raw,
                                        logic [DATA_W-1:0] val);
        word_t w;
        w = '0;
        w.cmd = CMD_LOAD;
        w.idx = IDX_W'(idx);
        w.raw = raw;
        w.val = val;
        w.smp = DATA_W'($urandom);
        return w;
    endfunction

    function automatic word_t conv_word(logic [DATA_W-1:0] x);
        word_t w;
        w.cmd = CMD_CONVERT;
        w.idx = IDX_W'($urandom);
        w.raw = DATA_W'($urandom);
        w.val = DATA_W'($urandom);
        w.smp = x;
        return w;
    endfunction

    // wait for the queue to drain and every result to come back, then let
    // trailing loads clear the pipe before touching the count
    task automatic settle();
        while (pending_words.size() > 0 || in_valid || expected_conv.size() > 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic set_points(int n);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= CNT_W'(n);
        @(negedge clk);
        cfg_we <= 1'b0;
        points_used = n;
    endtask

    // sorted random curve over all slots; occasionally duplicates or unordered
    task automatic queue_curve(bit messy);
        logic [DATA_W-1:0] xs [DEPTH];
        int step;
        xs[0] = DATA_W'($urandom_range(0, 4000));
        for (int i = 1; i < DEPTH; i++) begin
            step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8000);
            xs[i] = (xs[i-1] + step > 65535) ? 16'hFFFF : DATA_W'(xs[i-1] + step);
        end
        if (messy) xs[$urandom_range(0, DEPTH-1)] = DATA_W'($urandom);
        for (int i = 0; i < DEPTH; i++) begin
            pending_words.push_back(load_word(i, xs[i], DATA_W'($urandom)));
        end
    endtask

    // raw inputs as they will stand once queued loads are absorbed
    logic [DATA_W-1:0] curve_raw_next [DEPTH];

    function automatic logic [DATA_W-1:0] pick_sample(int n);
        int k;
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 5))
            0: return curve_raw_next[k];
            1: return DATA_W'($urandom);
            2: return (curve_raw_next[k] == 0) ? 16'd0 : curve_raw_next[k] - 16'd1;
            default: return curve_raw_next[k] + DATA_W'($urandom_range(0, 9000));
        endcase
    endfunction

    function automatic void shadow_loads();
        foreach (pending_words[i])
            if (pending_words[i].cmd == CMD_LOAD)
                curve_raw_next[pending_words[i].idx] = pending_words[i].raw;
    endfunction

    int counts[] = '{0, 1, 2, 16, 31, 3, 9, 17, 16, 5, 2, 12};

    initial begin
        points_used = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed: extreme curve, count 0 gives the short flag, count
        // 2 over full-range points, samples at and around the ends
        pending_words.push_back(load_word(0, 16'd0, 16'sh8000));
        pending_words.push_back(load_word(1, 16'hFFFF, 16'sh7FFF));
        for (int i = 2; i < DEPTH; i++)
            pending_words.push_back(load_word(i, 16'hFFFF, 16'sh7FFF));
        pending_words.push_back(conv_word(16'd0));
        pending_words.push_back(conv_word(16'hFFFF));
        settle();
        set_points(2);
        pending_words.push_back(conv_word(16'd0));
        pending_words.push_back(conv_word(16'd1));
        pending_words.push_back(conv_word(16'h8000));
        pending_words.push_back(conv_word(16'hFFFE));
        pending_words.push_back(conv_word(16'hFFFF));
        settle();
        // descending curve with a repeated breakpoint, sample below first point
        pending_words.push_back(load_word(0, 16'd100, 16'sh7FFF));
        pending_words.push_back(load_word(1, 16'd200, 16'sh8000));
        pending_words.push_back(load_word(2, 16'd200, 16'sd5));
        pending_words.push_back(conv_word(16'd50));
        pending_words.push_back(conv_word(16'd150));
        pending_words.push_back(conv_word(16'd200));
        pending_words.push_back(conv_word(16'd999));
        settle();
        set_points(3);
        pending_words.push_back(conv_word(16'd200));
        pending_words.push_back(conv_word(16'd201));
        settle();

        // random phases with varied point counts, extremes included
        foreach (counts[p]) begin
            int n;
            set_points(counts[p]);
            n = (counts[p] > DEPTH) ? DEPTH : counts[p];
            queue_curve($urandom_range(0, 3) == 0);
            foreach (curve_raw_next[i]) curve_raw_next[i] = curve_raw[i];
            shadow_loads();
            if (p == counts.size() - 1) gaps_on = 1'b0;
            for (int i = 0; i < 120; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    // reload a slot in range with a random point
                    pending_words.push_back(load_word($urandom_range(0, DEPTH - 1),
                                            DATA_W'($urandom), DATA_W'($urandom)));
                    shadow_loads();
                end else begin
                    pending_words.push_back(conv_word(pick_sample(n < 1 ? 1 : n)));
                end
            end
            if (p == 3) begin
                // long receiver hold-off while the sender keeps offering words
                hold_sink = 1'b1;
                wait (hold_done);
            end
            settle();
        end

        settle();
        if (errors == 0 && expected_conv.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pwli_pkg.sv
sv/pwli_ram.sv
sv/piecewise_linear_interpolator.sv
sv/pwli_checker.sv
sim/piecewise_linear_interpolator_tb.sv
